>>> sv/cih_pkg.sv
// Shared types, constants and helpers for the channel interval histogrammer.
// No dependencies.
package cih_pkg;

  localparam int TS_W     = 47;
  localparam int IV_W     = 48;
  localparam int CNT_W    = 32;
  localparam int CUT_W    = 16;
  localparam int BINW_W   = 32;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 64;

  localparam logic [1:0] REG_WIDTH_CUT    = 2'd0;
  localparam logic [1:0] REG_WINDOW_START = 2'd1;
  localparam logic [1:0] REG_WINDOW_END   = 2'd2;
  localparam logic [1:0] REG_BIN_WIDTH    = 2'd3;

  localparam logic [CUT_W-1:0]  RST_WIDTH_CUT    = 16'd0;
  localparam logic [TS_W-1:0]   RST_WINDOW_START = 47'd0;
  localparam logic [TS_W-1:0]   RST_WINDOW_END   = 47'd86399999999999;
  localparam logic [BINW_W-1:0] RST_BIN_WIDTH    = 32'd60000000;

  localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [CUT_W-1:0]  width_cut;
    logic [TS_W-1:0]   window_start;
    logic [TS_W-1:0]   window_end;
    logic [BINW_W-1:0] bin_width;
  } cih_cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

>>> sv/cih_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cih_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 520,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/cih_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on cih_pkg.
module cih_div import cih_pkg::*; #(
  parameter int DW = 47
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW-1:0]     dividend,
  input  logic [BINW_W-1:0] divisor,
  output logic              done,
  output logic [DW-1:0]     quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]     dq_r;
  logic [BINW_W-1:0] rem_r;
  logic [BINW_W-1:0] dvs_r;
  logic [CW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;

  logic [BINW_W:0]   shifted;
  logic [BINW_W+1:0] trial;
  logic              qbit;

  assign shifted = {rem_r, dq_r[DW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign qbit    = ~trial[BINW_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      dq_r  <= {dq_r[DW-2:0], qbit};
      rem_r <= qbit ? trial[BINW_W-1:0] : shifted[BINW_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> sv/cih_apb.sv
// Configuration register file behind an APB-style port.
// Depends on cih_pkg.
module cih_apb import cih_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cih_cfg_t           cfg
);

  cih_cfg_t   cfg_r;
  logic [1:0] idx;
  logic       wr;

  assign idx = paddr[PADDR_W-1:3];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_cut    <= RST_WIDTH_CUT;
      cfg_r.window_start <= RST_WINDOW_START;
      cfg_r.window_end   <= RST_WINDOW_END;
      cfg_r.bin_width    <= RST_BIN_WIDTH;
    end else if (wr) begin
      case (idx)
        REG_WIDTH_CUT:    cfg_r.width_cut    <= pwdata[CUT_W-1:0];
        REG_WINDOW_START: cfg_r.window_start <= pwdata[TS_W-1:0];
        REG_WINDOW_END:   cfg_r.window_end   <= pwdata[TS_W-1:0];
        REG_BIN_WIDTH:    cfg_r.bin_width    <= pwdata[BINW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH_CUT:    prdata = PDATA_W'(cfg_r.width_cut);
      REG_WINDOW_START: prdata = PDATA_W'(cfg_r.window_start);
      REG_WINDOW_END:   prdata = PDATA_W'(cfg_r.window_end);
      REG_BIN_WIDTH:    prdata = PDATA_W'(cfg_r.bin_width);
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> sv/channel_interval_histogrammer.sv
// Channel interval histogrammer top level: sequencer, channel time store, histogram RAM.
// Depends on cih_pkg, cih_apb, cih_div, cih_ram.
//
//   channel  direction  handshake           contents
//   in_      input      in_valid/in_ready   command, channel, timestamp, pulse_width, bin_index
//   out_     output     out_valid/out_ready one result item per input item
//   cfg_     APB slave  psel/penable/pready width_cut, window_start, window_end, bin_width
//
// An event with a non-negative interval passes through the bit-serial divider (ST_DIV).
// Rejected events and events without a previous time go from ST_DIFF to ST_DONE; negative
// intervals skip the divider; histogram reads skip ST_DIFF. One item is worked on at a time.
// After reset the histogram RAM is zeroed, one entry per cycle, all CHANNELS*(NUM_BINS+2)
// entries (520 by default), during which in_ready stays low.
// A finished result sits in the output register; the next item is taken meanwhile.
module channel_interval_histogrammer import cih_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int NUM_BINS = 128
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [1:0]              in_channel,
  input  logic [TS_W-1:0]         in_timestamp,
  input  logic [CUT_W-1:0]        in_pulse_width,
  input  logic [7:0]              in_bin_index,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_accepted,
  output logic                    out_has_interval,
  output logic signed [IV_W-1:0]  out_interval,
  output logic [7:0]              out_bin_hit,
  output logic                    out_negative,
  output logic [CNT_W-1:0]        out_negative_total,
  output logic [CNT_W-1:0]        out_read_count,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [PADDR_W-1:0]      cfg_paddr,
  input  logic [PDATA_W-1:0]      cfg_pwdata,
  output logic [PDATA_W-1:0]      cfg_prdata,
  output logic                    cfg_pready
);

  localparam int BPC   = NUM_BINS + 2;
  localparam int DEPTH = CHANNELS * BPC;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(BPC);
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_DIFF  = 4'd3;
  localparam logic [3:0] ST_SPLIT = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_ADDR  = 4'd6;
  localparam logic [3:0] ST_WAIT  = 4'd7;
  localparam logic [3:0] ST_UPD   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  cih_cfg_t cfg;

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r;
  logic                cmd_r;
  logic [1:0]          ch_r;
  logic [TS_W-1:0]     ts_r;
  logic [CUT_W-1:0]    pw_r;
  logic [7:0]          bidx_r;
  logic                acc_r;
  logic                hiv_r;
  logic                rd_ok_r;
  logic [IV_W-1:0]     diff_r;
  logic [BW-1:0]       bin_r;
  logic [AW-1:0]       addr_r;
  logic [CNT_W-1:0]    rc_r;
  logic [CNT_W-1:0]    neg_cnt_r;
  logic [TS_W-1:0]     last_time_r [CHANNELS];
  logic [CHANNELS-1:0] last_valid_r;

  logic                out_valid_r;
  logic                out_acc_r;
  logic                out_hiv_r;
  logic [IV_W-1:0]     out_iv_r;
  logic [7:0]          out_bin_r;
  logic                out_neg_r;
  logic [CNT_W-1:0]    out_negtot_r;
  logic [CNT_W-1:0]    out_rc_r;

  logic [CHW+1:0]      ch_ext;
  logic [CHW-1:0]      ch_idx;
  logic                ch_ok;
  logic [AW-1:0]       ch_base;
  logic [BW+7:0]       bin_ext;
  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic [TS_W-1:0]     div_q;
  logic [BINW_W-1:0]   divisor;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CNT_W-1:0]    ram_wdata;
  logic [CNT_W-1:0]    ram_rdata;

  assign ch_ext  = {{CHW{1'b0}}, ch_r};
  assign ch_idx  = ch_ext[CHW-1:0];
  assign ch_ok   = ({30'd0, ch_r} < 32'(CHANNELS));
  assign ch_base = AW'(ch_r) * AW'(BPC);
  assign bin_ext = {8'd0, bin_r};
  assign divisor = (cfg.bin_width == '0) ? BINW_W'(1) : cfg.bin_width;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign div_start = (state_r == ST_SPLIT) && !diff_r[IV_W-1];

  cih_apb u_apb (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );
  assign cfg_pready = 1'b1;

  cih_div #(.DW(TS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_r[TS_W-1:0]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign ram_we    = (state_r == ST_CLEAR) || ((state_r == ST_UPD) && !cmd_r);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : sat_inc(ram_rdata);

  cih_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = cmd_r ? ST_WAIT : ST_DIFF;
      ST_DIFF:  state_nxt = (acc_r && last_valid_r[ch_idx]) ? ST_SPLIT : ST_DONE;
      ST_SPLIT: state_nxt = diff_r[IV_W-1] ? ST_ADDR : ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      neg_cnt_r    <= '0;
      last_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if ((state_r == ST_SPLIT) && diff_r[IV_W-1]) begin
        neg_cnt_r <= sat_inc(neg_cnt_r);
      end
      if (out_load && acc_r) begin
        last_valid_r[ch_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r  <= in_command;
          ch_r   <= in_channel;
          ts_r   <= in_timestamp;
          pw_r   <= in_pulse_width;
          bidx_r <= in_bin_index;
        end
      end
      ST_CHECK: begin
        acc_r   <= !cmd_r && ch_ok && (pw_r > cfg.width_cut) &&
                   (ts_r >= cfg.window_start) && (ts_r <= cfg.window_end);
        hiv_r   <= 1'b0;
        rd_ok_r <= ch_ok && ({24'd0, bidx_r} < 32'(BPC));
        addr_r  <= ch_base + AW'(bidx_r);
      end
      ST_DIFF: begin
        hiv_r  <= acc_r && last_valid_r[ch_idx];
        diff_r <= {1'b0, ts_r} - {1'b0, last_time_r[ch_idx]};
      end
      ST_SPLIT: begin
        if (diff_r[IV_W-1]) begin
          bin_r <= '0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          bin_r <= (div_q >= TS_W'(NUM_BINS)) ? BW'(NUM_BINS + 1) : BW'(div_q) + BW'(1);
        end
      end
      ST_ADDR: addr_r <= ch_base + AW'(bin_r);
      ST_UPD:  rc_r <= (cmd_r && rd_ok_r) ? ram_rdata : '0;
      ST_DONE: begin
        if (out_load) begin
          if (acc_r) begin
            last_time_r[ch_idx] <= ts_r;
          end
          out_acc_r    <= acc_r;
          out_hiv_r    <= hiv_r;
          out_iv_r     <= hiv_r ? diff_r : '0;
          out_bin_r    <= hiv_r ? bin_ext[7:0] : '0;
          out_neg_r    <= hiv_r && diff_r[IV_W-1];
          out_negtot_r <= neg_cnt_r;
          out_rc_r     <= cmd_r ? rc_r : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_has_interval   = out_hiv_r;
  assign out_interval       = out_iv_r;
  assign out_bin_hit        = out_bin_r;
  assign out_negative       = out_neg_r;
  assign out_negative_total = out_negtot_r;
  assign out_read_count     = out_rc_r;

endmodule
